/* rtl/kipa_pkg.sv */
// Package with the shared types and codes of the keyed instance pool admission block.
package kipa_pkg;

  // Function codes of a request.
  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Instance kinds.
  localparam logic KIND_EXCLUSIVE = 1'b0;
  localparam logic KIND_SHARED    = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CANCEL  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_WAIT    = 3'd4;

  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

  typedef struct packed {
    logic        func;
    logic        kind;
    logic [63:0] key_id;
    logic [7:0]  per_key_limit;
    logic        cancelled;
    logic        timed_out;
    logic [3:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic        created;
    logic [15:0] holders;
  } rsp_t;

  // One slot of the instance table as held in memory.
  typedef struct packed {
    logic              kind;
    logic [63:0]       key;
    logic [HOLD_W-1:0] holders;
  } entry_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_REL
  } state_e;

endpackage

/* rtl/kipa_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module kipa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kipa_match.sv */
// Shared compare unit: matches one slot per cycle and accumulates count and oldest usable slot.
module kipa_match
  import kipa_pkg::*;
#(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  entry_t            entry_i,
  input  logic              kind_i,
  input  logic [63:0]       key_i,
  output logic              found_o,
  output logic [IDX_W-1:0]  pick_o,
  output logic [HOLD_W-1:0] pick_holders_o,
  output logic [CNT_W-1:0]  count_o
);

  logic              found_q, found_d;
  logic [IDX_W-1:0]  pick_q, pick_d;
  logic [HOLD_W-1:0] pick_hold_q, pick_hold_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              hit;
  logic              usable;

  assign hit    = ctl_i.valid && (entry_i.kind == kind_i) && (entry_i.key == key_i);
  assign usable = (entry_i.holders != HOLD_MAX) &&
                  ((entry_i.holders == '0) || (kind_i == KIND_SHARED));

  always_comb begin
    found_d     = found_q;
    pick_d      = pick_q;
    pick_hold_d = pick_hold_q;
    count_d     = count_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
      count_d = '0;
    end else if (hit) begin
      count_d = count_q + 1'b1;
      if (!found_q && usable) begin
        found_d     = 1'b1;
        pick_d      = idx_i;
        pick_hold_d = entry_i.holders;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      count_q <= '0;
    end else begin
      found_q <= found_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q      <= pick_d;
    pick_hold_q <= pick_hold_d;
  end

  assign found_o        = found_q;
  assign pick_o         = pick_q;
  assign pick_holders_o = pick_hold_q;
  assign count_o        = count_q;

endmodule

/* rtl/keyed_instance_pool_admission_top.sv */
// Top level of the keyed instance pool admission block: sequencer, slot table and compare unit.
//
//   Channel   | Ports                   | Handshake
//   ----------+-------------------------+------------------------------------------
//   request   | start_i, busy_o, req_i  | item taken at a clock edge with start_i
//             |                         | high and busy_o low
//   result    | done_o, rsp_o           | one-cycle strobe, receiver cannot stall
//
// A release of a valid slot passes through the check and release states; other releases and
// cancelled or timed-out acquires end in the check state. Any other acquire scans every used
// slot (none with an empty table) before it reaches the decide state: the slot table sits
// in one RAM whose single read port feeds one compare unit a slot per cycle, lowest first.
// Reset clears the fill count and the sequencer; slot contents need no clearing, since
// only slots below the fill count are ever read. The result strobe shows in the cycle
// after the last step of an item, while busy_o is already low, so the next item can be
// accepted in that same cycle. The receiver has no way to stall the block.
module keyed_instance_pool_admission_top
  import kipa_pkg::*;
#(
  parameter int unsigned MAX_INSTANCES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  // Index width addresses the table; the fill count must also hold the full size.
  localparam int unsigned IDX_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int unsigned USE_W = $clog2(MAX_INSTANCES + 1);
  localparam int unsigned ENT_W = $bits(entry_t);

  state_e state_q, state_d;

  req_t             req_q;
  logic [USE_W-1:0] used_q, used_d;
  logic [USE_W-1:0] scan_idx_q, scan_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  // Table memory ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  // Compare unit interface.
  scan_ctl_t         scan_ctl;
  logic              found;
  logic [IDX_W-1:0]  pick;
  logic [HOLD_W-1:0] pick_holders;
  logic [USE_W-1:0]  match_count;

  // Derived values used by the sequencer.
  logic [USE_W+SLOT_W-1:0] slot_in_ext;
  logic [USE_W+SLOT_W-1:0] used_ext;
  logic [IDX_W+SLOT_W-1:0] rel_ext;
  logic [IDX_W+SLOT_W-1:0] pick_ext;
  logic [USE_W+SLOT_W-1:0] new_ext;
  logic                    rel_ok;
  logic [IDX_W-1:0]        rel_addr;
  logic [7:0]              limit_eff;
  logic                    limit_hit;
  logic [HOLD_W-1:0]       rel_holders;

  assign slot_in_ext = {{USE_W{1'b0}}, req_q.slot_in};
  assign used_ext    = {{SLOT_W{1'b0}}, used_q};
  assign rel_ext     = {{IDX_W{1'b0}}, req_q.slot_in};
  assign pick_ext    = {{SLOT_W{1'b0}}, pick};
  assign new_ext     = {{SLOT_W{1'b0}}, used_q};

  // A slot is valid exactly when its index is below the fill count.
  assign rel_ok   = slot_in_ext < used_ext;
  assign rel_addr = rel_ext[IDX_W-1:0];

  // A zero per-key limit acts as a limit of one.
  assign limit_eff = (req_q.per_key_limit == 8'd0) ? 8'd1 : req_q.per_key_limit;
  assign limit_hit = {8'd0, match_count} >= {{USE_W{1'b0}}, limit_eff};

  // Release decrements, saturating at zero.
  assign rel_holders = (ram_rdata.holders == '0) ? '0 : ram_rdata.holders - 1'b1;

  kipa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_INSTANCES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  kipa_match #(
    .IDX_W(IDX_W),
    .CNT_W(USE_W)
  ) u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .idx_i         (cmp_idx_q),
    .entry_i       (ram_rdata),
    .kind_i        (req_q.kind),
    .key_i         (req_q.key_id),
    .found_o       (found),
    .pick_o        (pick),
    .pick_holders_o(pick_holders),
    .count_o       (match_count)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (req_q.func == FUNC_RELEASE) begin
          state_d = rel_ok ? S_REL : S_IDLE;
        end else if (req_q.cancelled || req_q.timed_out) begin
          state_d = S_IDLE;
        end else if (used_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_q + 1'b1 == used_q) begin
          state_d = S_LAST;
        end
      end
      S_LAST:   state_d = S_DECIDE;
      S_DECIDE: state_d = S_IDLE;
      S_REL:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Output and datapath control of the sequencer.
  always_comb begin
    used_d         = used_q;
    scan_idx_d     = scan_idx_q;
    cmp_vld_d      = (state_q == S_SCAN);
    cmp_idx_d      = scan_idx_q[IDX_W-1:0];
    done_d         = 1'b0;
    rsp_d          = '0;
    ram_we         = 1'b0;
    ram_waddr      = pick;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = scan_idx_q[IDX_W-1:0];
    scan_ctl.clear = 1'b0;
    scan_ctl.valid = cmp_vld_q;
    case (state_q)
      S_CHECK: begin
        scan_idx_d     = '0;
        scan_ctl.clear = 1'b1;
        if (req_q.func == FUNC_RELEASE) begin
          if (rel_ok) begin
            ram_re    = 1'b1;
            ram_raddr = rel_addr;
          end else begin
            // Release of a slot that was never created changes nothing.
            done_d         = 1'b1;
            rsp_d.status   = ST_OK;
            rsp_d.slot_out = req_q.slot_in;
          end
        end else if (req_q.cancelled) begin
          done_d       = 1'b1;
          rsp_d.status = ST_CANCEL;
        end else if (req_q.timed_out) begin
          done_d       = 1'b1;
          rsp_d.status = ST_TIMEOUT;
        end
      end
      S_SCAN: begin
        ram_re     = 1'b1;
        ram_raddr  = scan_idx_q[IDX_W-1:0];
        scan_idx_d = scan_idx_q + 1'b1;
      end
      S_DECIDE: begin
        done_d = 1'b1;
        if (found) begin
          ram_we         = 1'b1;
          ram_waddr      = pick;
          ram_wdata      = '{kind: req_q.kind, key: req_q.key_id, holders: pick_holders + 1'b1};
          rsp_d.status   = ST_OK;
          rsp_d.slot_out = pick_ext[SLOT_W-1:0];
          rsp_d.holders  = pick_holders + 1'b1;
        end else if (limit_hit) begin
          rsp_d.status = ST_WAIT;
        end else if (used_ext >= (USE_W + SLOT_W)'(MAX_INSTANCES)) begin
          rsp_d.status = ST_FULL;
        end else begin
          // New slots are appended, so the fill count is the next free index.
          ram_we         = 1'b1;
          ram_waddr      = used_q[IDX_W-1:0];
          ram_wdata      = '{kind: req_q.kind, key: req_q.key_id, holders: HOLD_W'(1)};
          used_d         = used_q + 1'b1;
          rsp_d.status   = ST_OK;
          rsp_d.slot_out = new_ext[SLOT_W-1:0];
          rsp_d.created  = 1'b1;
          rsp_d.holders  = HOLD_W'(1);
        end
      end
      S_REL: begin
        done_d         = 1'b1;
        ram_we         = 1'b1;
        ram_waddr      = rel_addr;
        ram_wdata      = '{kind: ram_rdata.kind, key: ram_rdata.key, holders: rel_holders};
        rsp_d.status   = ST_OK;
        rsp_d.slot_out = req_q.slot_in;
        rsp_d.holders  = rel_holders;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      req_q <= req_i;
    end
    cmp_idx_q <= cmp_idx_d;
    rsp_q     <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/kipa_checker.sv */
// Port-level checker for the keyed instance pool admission block, with its bind statement.
module kipa_checker
  import kipa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting an item");

  // A result strobe is never directly followed by another.
  a_no_double_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // A result is shown only once the block is ready again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A newly created slot is granted with exactly one holder.
  a_created_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.created) |-> (rsp_o.status == ST_OK && rsp_o.holders == 16'd1))
    else $error("created slot with wrong status or holder count");

  // Refusals carry no slot, no holder count and no creation flag.
  a_refusal_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |->
      (rsp_o.slot_out == 4'd0 && rsp_o.holders == 16'd0 && !rsp_o.created &&
       (rsp_o.status == ST_CANCEL || rsp_o.status == ST_TIMEOUT ||
        rsp_o.status == ST_FULL || rsp_o.status == ST_WAIT)))
    else $error("malformed refusal result");

endmodule

bind keyed_instance_pool_admission_top kipa_checker u_kipa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

/* verif/testbench.sv */
// Self-checking testbench for the keyed instance pool admission block.
`timescale 1ns / 1ps

module testbench;
  import kipa_pkg::*;

  // The table depth under test; the predictor mirrors a table of the same size.
  localparam int unsigned POOL_DEPTH = 16;
  // Cycles without any accepted item or result before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles to keep watching for stray results once nothing is expected.
  localparam int unsigned TAIL_CYCLES = 30;
  // Random items per phase; three phases make about 1600 items.
  localparam int unsigned PHASE_ITEMS = 534;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  // One row of the directed stimulus table. A row may repeat its item, and it carries
  // a typed-in outcome only where that outcome is obvious; otherwise the predictor
  // supplies it.
  typedef struct {
    req_t        item;
    int unsigned reps;
    bit          typed;
    rsp_t        outcome;
  } plan_row_t;

  plan_row_t plan[$];

  // Outcomes of accepted items that have not come back yet, oldest first.
  rsp_t pending_outcomes[$];

  // The predictor's own copy of the slot table.
  logic                pv_valid [POOL_DEPTH];
  logic                pv_kind  [POOL_DEPTH];
  logic [63:0]         pv_key   [POOL_DEPTH];
  logic [HOLD_W-1:0]   pv_hold  [POOL_DEPTH];
  int unsigned         pv_used;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  // Percentage of cycles in which the sender holds back before offering an item.
  int unsigned idle_pct = 0;

  keyed_instance_pool_admission_top #(
    .MAX_INSTANCES(POOL_DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic req_t make_req(logic func, logic kind, logic [63:0] key,
                                    logic [7:0] lim, logic canc, logic tout,
                                    logic [3:0] slot);
    req_t r;
    r.func          = func;
    r.kind          = kind;
    r.key_id        = key;
    r.per_key_limit = lim;
    r.cancelled     = canc;
    r.timed_out     = tout;
    r.slot_in       = slot;
    return r;
  endfunction

  function automatic rsp_t make_rsp(logic [2:0] st, logic [3:0] slot, logic cr,
                                    logic [15:0] hold);
    rsp_t o;
    o.status   = st;
    o.slot_out = slot;
    o.created  = cr;
    o.holders  = hold;
    return o;
  endfunction

  task automatic plan_add(req_t item, int unsigned reps, bit typed, rsp_t outcome);
    plan_row_t row;
    row.item    = item;
    row.reps    = reps;
    row.typed   = typed;
    row.outcome = outcome;
    plan.push_back(row);
  endtask

  // Admission decision for one item, applied to the mirrored table. A release lowers
  // the holder count of a valid slot, never below zero. An acquire looks at cancel,
  // then timeout, then grants the lowest matching slot that is idle (or any matching
  // slot for the shared kind) unless its count is saturated, then answers wait at the
  // key's limit, then table full, and otherwise creates a slot.
  function automatic rsp_t pool_admit(req_t r);
    rsp_t        o;
    int unsigned match_cnt;
    int          pick;
    int          i;
    logic [7:0]  lim;
    o = make_rsp(ST_OK, '0, 1'b0, '0);
    if (r.func == FUNC_RELEASE) begin
      o.slot_out = r.slot_in;
      if (r.slot_in < POOL_DEPTH && pv_valid[r.slot_in]) begin
        if (pv_hold[r.slot_in] != '0) pv_hold[r.slot_in] = pv_hold[r.slot_in] - 1'b1;
        o.holders = pv_hold[r.slot_in];
      end
      return o;
    end
    if (r.cancelled) begin
      o.status = ST_CANCEL;
      return o;
    end
    if (r.timed_out) begin
      o.status = ST_TIMEOUT;
      return o;
    end
    lim = (r.per_key_limit == 8'd0) ? 8'd1 : r.per_key_limit;
    match_cnt = 0;
    pick = -1;
    for (i = 0; i < POOL_DEPTH; i++) begin
      if (pv_valid[i] && pv_kind[i] == r.kind && pv_key[i] == r.key_id) begin
        match_cnt++;
        if (pick < 0 && pv_hold[i] != HOLD_MAX &&
            (pv_hold[i] == '0 || r.kind == KIND_SHARED)) pick = i;
      end
    end
    if (pick >= 0) begin
      pv_hold[pick] = pv_hold[pick] + 1'b1;
      o.slot_out = SLOT_W'(pick);
      o.holders  = pv_hold[pick];
    end else if (match_cnt >= lim) begin
      o.status = ST_WAIT;
    end else if (pv_used >= POOL_DEPTH) begin
      o.status = ST_FULL;
    end else begin
      pv_valid[pv_used] = 1'b1;
      pv_kind[pv_used]  = r.kind;
      pv_key[pv_used]   = r.key_id;
      pv_hold[pv_used]  = 16'd1;
      o.slot_out = SLOT_W'(pv_used);
      o.created  = 1'b1;
      o.holders  = 16'd1;
      pv_used++;
    end
    return o;
  endfunction

  // Offers one item and returns at the edge that accepts it, with start_i still high
  // so that a following item can go out back to back. Before the offer the sender may
  // hold back for a random number of cycles.
  task automatic send_item(req_t item, bit typed, rsp_t outcome);
    rsp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= item;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    // The predictor runs on every accepted item so that its table stays in step, even
    // where the row supplies the outcome itself.
    predicted = pool_admit(item);
    pending_outcomes.push_back(typed ? outcome : predicted);
  endtask

  // Holds the sender back until every outstanding result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Result checker: every strobe must match the oldest outstanding outcome field by
  // field; a strobe with nothing outstanding is a failure of its own.
  always @(posedge clk_i) begin
    rsp_t want;
    bit   ok;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, rsp_o);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        ok = 1'b1;
        ok &= field_ok("status", 16'(want.status), 16'(rsp_o.status));
        ok &= field_ok("slot_out", 16'(want.slot_out), 16'(rsp_o.slot_out));
        ok &= field_ok("created", 16'(want.created), 16'(rsp_o.created));
        ok &= field_ok("holders", want.holders, rsp_o.holders);
        if (!ok) mismatches++;
      end
    end
  end

  // Watchdog: a hung handshake shows as a long stretch with no accepted item and no
  // result.
  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    req_t        r;
    int unsigned roll;
    int unsigned pick;
    int unsigned phase;
    int unsigned n;
    int unsigned k;

    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    pv_used = 0;
    for (k = 0; k < POOL_DEPTH; k++) begin
      pv_valid[k] = 1'b0;
      pv_kind[k]  = 1'b0;
      pv_key[k]   = '0;
      pv_hold[k]  = '0;
    end

    // Directed table. It starts from an empty table, so the first rows have outcomes
    // that can be written down directly.
    plan_add(make_req(FUNC_RELEASE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd0), 1,
             1'b1, make_rsp(ST_OK, 4'd0, 1'b0, 16'd0));
    // A release ignores both flags, and slot 15 is not yet valid.
    plan_add(make_req(FUNC_RELEASE, KIND_SHARED, '1, 8'd255, 1'b1, 1'b1, 4'd15), 1,
             1'b1, make_rsp(ST_OK, 4'd15, 1'b0, 16'd0));
    // Cancel wins over timeout.
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, '0, 8'd0, 1'b1, 1'b1, 4'd0), 1,
             1'b1, make_rsp(ST_CANCEL, 4'd0, 1'b0, 16'd0));
    plan_add(make_req(FUNC_ACQUIRE, KIND_SHARED, '1, 8'd255, 1'b0, 1'b1, 4'd15), 1,
             1'b1, make_rsp(ST_TIMEOUT, 4'd0, 1'b0, 16'd0));
    // A zero limit acts as one: the first acquire creates slot 0.
    plan_add(make_req(FUNC_ACQUIRE, KIND_SHARED, '1, 8'd0, 1'b0, 1'b0, 4'd0), 1,
             1'b1, make_rsp(ST_OK, 4'd0, 1'b1, 16'd1));
    // A shared slot is granted again while it is held.
    plan_add(make_req(FUNC_ACQUIRE, KIND_SHARED, '1, 8'd0, 1'b0, 1'b0, 4'd0), 3,
             1'b0, '0);
    plan_add(make_req(FUNC_RELEASE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd0), 1,
             1'b0, '0);
    plan_add(make_req(FUNC_ACQUIRE, KIND_SHARED, '1, 8'd2, 1'b0, 1'b0, 4'd0), 1,
             1'b0, '0);
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd0), 1,
             1'b1, make_rsp(ST_OK, 4'd1, 1'b1, 16'd1));
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd0), 1,
             1'b1, make_rsp(ST_WAIT, 4'd0, 1'b0, 16'd0));
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, '0, 8'd255, 1'b0, 1'b0, 4'd0), 1,
             1'b0, '0);
    // Release slot 1 twice: the second release finds it idle and leaves it at zero.
    plan_add(make_req(FUNC_RELEASE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd1), 2,
             1'b0, '0);
    plan_add(make_req(FUNC_RELEASE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd2), 1,
             1'b0, '0);
    // Slots 1 and 2 are both idle; the lower index must be granted.
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, '0, 8'd255, 1'b0, 1'b0, 4'd0), 1,
             1'b0, '0);
    // Same key, other kind: no match, so a new slot is created.
    plan_add(make_req(FUNC_ACQUIRE, KIND_SHARED, '0, 8'd1, 1'b0, 1'b0, 4'd0), 1,
             1'b0, '0);
    plan_add(make_req(FUNC_RELEASE, KIND_SHARED, '1, 8'd7, 1'b1, 1'b0, 4'd9), 1,
             1'b1, make_rsp(ST_OK, 4'd9, 1'b0, 16'd0));
    // Fill the rest of the table with one busy exclusive key.
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, 64'hA5A5_A5A5_A5A5_A5A5, 8'd255,
                      1'b0, 1'b0, 4'd0), 12, 1'b0, '0);
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, 64'hA5A5_A5A5_A5A5_A5A5, 8'd255,
                      1'b0, 1'b0, 4'd0), 1, 1'b1, make_rsp(ST_FULL, 4'd0, 1'b0, 16'd0));
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, 64'h5A5A_5A5A_5A5A_5A5A, 8'd0,
                      1'b0, 1'b0, 4'd0), 1, 1'b1, make_rsp(ST_FULL, 4'd0, 1'b0, 16'd0));
    plan_add(make_req(FUNC_RELEASE, KIND_EXCLUSIVE, '0, 8'd0, 1'b0, 1'b0, 4'd15), 1,
             1'b0, '0);
    plan_add(make_req(FUNC_ACQUIRE, KIND_EXCLUSIVE, 64'hA5A5_A5A5_A5A5_A5A5, 8'd0,
                      1'b0, 1'b0, 4'd0), 1, 1'b0, '0);

    // Reset is applied once and released at a clock edge.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // The directed rows go out back to back.
    idle_pct = 0;
    foreach (plan[row]) begin
      for (n = 0; n < plan[row].reps; n++) begin
        send_item(plan[row].item, plan[row].typed, plan[row].outcome);
      end
    end
    drain_results();

    // Random items in three phases: a lightly idling sender, a heavily idling sender,
    // and a sender that never idles. The table is full by now, so most acquires reuse
    // the key and kind of an existing slot to reach grants and waits; a few use random
    // keys, which see a full table.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 24 : (phase == 1) ? 67 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        r.func          = (roll < 45) ? FUNC_RELEASE : FUNC_ACQUIRE;
        r.kind          = 1'($urandom_range(1));
        r.key_id        = {$urandom, $urandom};
        r.per_key_limit = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        r.cancelled     = ($urandom_range(9) == 0);
        r.timed_out     = ($urandom_range(9) == 0);
        r.slot_in       = 4'($urandom_range(15));
        if (r.func == FUNC_ACQUIRE && roll < 93 && pv_used != 0) begin
          pick = $urandom_range(pv_used - 1);
          r.kind   = pv_kind[pick];
          r.key_id = pv_key[pick];
        end
        send_item(r, 1'b0, '0);
        // Now and then the sender waits for every result before going on.
        if ($urandom_range(49) == 0) drain_results();
      end
      drain_results();
    end

    // Everything has come back; keep watching a little longer for stray strobes.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
